// ----- hdl/vsp_pkg.sv -----
// Shared character codes, result type and digit helper for the version string parser.
package vsp_pkg;

  // Character codes that the grammar looks at.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // One parsed version, as delivered on the result channel.
  typedef struct packed {
    logic        valid_res;
    logic [15:0] major_value;
    logic [15:0] minor_value;
    logic [31:0] patch_value;
    logic [31:0] build_value;
  } vsp_res_t;

  // Decimal accumulate modulo 2^32: acc * 10 + digit, built from two shifts.
  function automatic logic [31:0] mul10_add(input logic [31:0] acc, input logic [3:0] digit);
    logic [31:0] times8;
    logic [31:0] times2;
    times8 = {acc[28:0], 3'b000};
    times2 = {acc[30:0], 1'b0};
    return times8 + times2 + {28'd0, digit};
  endfunction

endpackage

// ----- hdl/vsp_in_reg.sv -----
// Input register stage that holds one character until the parser takes it.
module vsp_in_reg
  import vsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_symbol,
  input  logic       advance,
  output logic       hold_vld,
  output logic [7:0] hold_sym
);

  logic       vld_r;
  logic       vld_nxt;
  logic [7:0] sym_r;

  // The stage is free when empty or when its character moves on this cycle.
  assign in_ready = !vld_r || advance;
  assign vld_nxt  = in_ready ? in_valid : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload capture on every transfer.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sym_r <= in_symbol;
    end
  end

  assign hold_vld = vld_r;
  assign hold_sym = sym_r;

endmodule

// ----- hdl/vsp_parse_core.sv -----
// Grammar state machine and digit accumulators of the version string parser.
module vsp_parse_core
  import vsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] sym,
  output logic       is_end,
  output vsp_res_t   res
);

  typedef enum logic [3:0] {
    PH_LEAD,
    PH_MAJOR,
    PH_DOT1,
    PH_MINOR,
    PH_DOT2,
    PH_PATCH,
    PH_SPACES,
    PH_BUILD,
    PH_DONE,
    PH_INVALID
  } phase_t;

  phase_t      phase_r;
  phase_t      phase_nxt;
  logic [31:0] acc_r;
  logic [31:0] acc_nxt;
  logic [15:0] major_r;
  logic [15:0] major_nxt;
  logic [15:0] minor_r;
  logic [15:0] minor_nxt;
  logic [31:0] patch_r;
  logic [31:0] patch_nxt;
  logic [31:0] build_r;
  logic [31:0] build_nxt;

  logic        is_digit;
  logic [3:0]  digit;
  logic [7:0]  digit_wide;
  logic [31:0] acc_step;
  logic [31:0] acc_start;

  // Character classification and the two accumulator candidates.
  assign is_end     = (sym == CH_NUL);
  assign is_digit   = (sym >= CH_ZERO) && (sym <= CH_NINE);
  assign digit_wide = sym - CH_ZERO;
  assign digit      = digit_wide[3:0];
  assign acc_step   = mul10_add(acc_r, digit);
  assign acc_start  = {28'd0, digit};

  // Next state for one character, and the result that an end character yields.
  always_comb begin
    logic        ok;
    logic [15:0] maj_f;
    logic [15:0] min_f;
    logic [31:0] pat_f;
    logic [31:0] bld_f;

    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    major_nxt = major_r;
    minor_nxt = minor_r;
    patch_nxt = patch_r;
    build_nxt = build_r;
    ok        = 1'b0;
    maj_f     = major_r;
    min_f     = minor_r;
    pat_f     = patch_r;
    bld_f     = build_r;

    if (is_end) begin
      // The open number, if any, is closed into its store before the verdict.
      unique case (phase_r)
        PH_MAJOR: begin
          maj_f = acc_r[15:0];
          ok    = 1'b1;
        end
        PH_MINOR: begin
          min_f = acc_r[15:0];
          ok    = 1'b1;
        end
        PH_PATCH: begin
          pat_f = acc_r;
          ok    = 1'b1;
        end
        PH_SPACES: ok = 1'b1;
        PH_BUILD: begin
          bld_f = acc_r;
          ok    = 1'b1;
        end
        PH_DONE: ok = 1'b1;
        default: ok = 1'b0;
      endcase
      // Every string ends with a return to the start state.
      phase_nxt = PH_LEAD;
      acc_nxt   = '0;
      major_nxt = '0;
      minor_nxt = '0;
      patch_nxt = '0;
      build_nxt = '0;
    end else begin
      unique case (phase_r)
        PH_LEAD: begin
          if (sym == CH_SPACE) begin
            phase_nxt = PH_LEAD;
          end else if (is_digit) begin
            acc_nxt   = acc_start;
            phase_nxt = PH_MAJOR;
          end else begin
            phase_nxt = PH_INVALID;
          end
        end
        PH_MAJOR: begin
          if (is_digit) begin
            acc_nxt = acc_step;
          end else if (sym == CH_DOT) begin
            major_nxt = acc_r[15:0];
            phase_nxt = PH_DOT1;
          end else begin
            phase_nxt = PH_INVALID;
          end
        end
        PH_DOT1: begin
          if (is_digit) begin
            acc_nxt   = acc_start;
            phase_nxt = PH_MINOR;
          end else begin
            phase_nxt = PH_INVALID;
          end
        end
        PH_MINOR: begin
          if (is_digit) begin
            acc_nxt = acc_step;
          end else if (sym == CH_DOT) begin
            minor_nxt = acc_r[15:0];
            phase_nxt = PH_DOT2;
          end else begin
            phase_nxt = PH_INVALID;
          end
        end
        PH_DOT2: begin
          if (is_digit) begin
            acc_nxt   = acc_start;
            phase_nxt = PH_PATCH;
          end else begin
            phase_nxt = PH_INVALID;
          end
        end
        PH_PATCH: begin
          if (is_digit) begin
            acc_nxt = acc_step;
          end else if (sym == CH_SPACE) begin
            patch_nxt = acc_r;
            phase_nxt = PH_SPACES;
          end else begin
            phase_nxt = PH_INVALID;
          end
        end
        PH_SPACES: begin
          if (sym == CH_SPACE) begin
            phase_nxt = PH_SPACES;
          end else if (is_digit) begin
            acc_nxt   = acc_start;
            phase_nxt = PH_BUILD;
          end else begin
            phase_nxt = PH_INVALID;
          end
        end
        PH_BUILD: begin
          // Any non-digit closes the build number; the rest is trailing text.
          if (is_digit) begin
            acc_nxt = acc_step;
          end else begin
            build_nxt = acc_r;
            phase_nxt = PH_DONE;
          end
        end
        PH_DONE:    phase_nxt = PH_DONE;
        PH_INVALID: phase_nxt = PH_INVALID;
        default:    phase_nxt = PH_INVALID;
      endcase
    end

    // A rejected string reports zeros in every field.
    res.valid_res   = ok;
    res.major_value = ok ? maj_f : 16'd0;
    res.minor_value = ok ? min_f : 16'd0;
    res.patch_value = ok ? pat_f : 32'd0;
    res.build_value = ok ? bld_f : 32'd0;
  end

  // Parser state advances only when a character is consumed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEAD;
      acc_r   <= '0;
      major_r <= '0;
      minor_r <= '0;
      patch_r <= '0;
      build_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      major_r <= major_nxt;
      minor_r <= minor_nxt;
      patch_r <= patch_nxt;
      build_r <= build_nxt;
    end
  end

endmodule

// ----- hdl/vsp_out_reg.sv -----
// Result register that holds one parsed version until the consumer takes it.
module vsp_out_reg
  import vsp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     load,
  input  vsp_res_t res_in,
  input  logic     out_ready,
  output logic     free,
  output logic     out_valid,
  output vsp_res_t res_out
);

  logic     vld_r;
  logic     vld_nxt;
  vsp_res_t res_r;

  // The register can take a new result when empty or drained this cycle.
  assign free    = !vld_r || out_ready;
  assign vld_nxt = load ? 1'b1 : (out_ready ? 1'b0 : vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = vld_r;
  assign res_out   = res_r;

endmodule

// ----- hdl/version_string_parser.sv -----
// Top level of the version string parser: input stage, grammar core and result register.
//
//   Channel  Ports                                   Direction  Transfer moves
//   input    in_valid, in_ready, in_symbol           in         one character
//   result   out_valid, out_ready, out_valid_res,    out        one parsed version
//            out_major_value .. out_build_value
//
// One character is consumed per cycle while no end character waits on a busy result
// register; the grammar state and the multiply-by-ten accumulator update at the edge
// where a character leaves the input register. A result appears on out_* at the edge
// where its end character leaves the input register.
// Reset (rst_n low, synchronous) empties both registers and returns to the start state.
// A stalled result register holds back only an end character; other characters keep flowing.
module version_string_parser
  import vsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_symbol,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_valid_res,
  output logic [15:0] out_major_value,
  output logic [15:0] out_minor_value,
  output logic [31:0] out_patch_value,
  output logic [31:0] out_build_value
);

  logic       hold_vld;
  logic [7:0] hold_sym;
  logic       advance;
  logic       is_end;
  logic       out_free;
  vsp_res_t   core_res;
  vsp_res_t   res_q;

  // A held character moves on unless it ends a string and the result slot is busy.
  assign advance = hold_vld && (!is_end || out_free);

  vsp_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_symbol(in_symbol),
    .advance  (advance),
    .hold_vld (hold_vld),
    .hold_sym (hold_sym)
  );

  vsp_parse_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .sym   (hold_sym),
    .is_end(is_end),
    .res   (core_res)
  );

  vsp_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (advance && is_end),
    .res_in   (core_res),
    .out_ready(out_ready),
    .free     (out_free),
    .out_valid(out_valid),
    .res_out  (res_q)
  );

  assign out_valid_res   = res_q.valid_res;
  assign out_major_value = res_q.major_value;
  assign out_minor_value = res_q.minor_value;
  assign out_patch_value = res_q.patch_value;
  assign out_build_value = res_q.build_value;

  // An end character that moves on always leaves a result behind.
  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && is_end) |=> out_valid)
    else $error("end character consumed without a result");

  // A rejected string carries zeros in every numeric field.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_valid_res) |-> (out_major_value == 16'd0 && out_minor_value == 16'd0
      && out_patch_value == 32'd0 && out_build_value == 32'd0))
    else $error("rejected result with nonzero fields");

  // An end character never overwrites a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready && hold_vld && is_end) |-> !advance)
    else $error("result overwritten while stalled");

endmodule
